/* src/text_console_writer_top_assert.svh */
// Assertion macros shared by the text console writer modules.
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/tcw_pkg.sv */
// Types and constants for the text console writer.
`default_nettype none
package tcw_pkg;

  typedef struct packed {
    logic        action;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [15:0] cell_value;
    logic        scrolled;
  } tcw_out_t;

  // What a put does to the screen: write one cell, and/or start a scroll.
  typedef struct packed {
    logic cell_wr;
    logic scroll;
  } tcw_plan_t;

  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [7:0] CODE_NEWLINE   = 8'd10;
  localparam logic [7:0] CODE_BACKSPACE = 8'd8;
  localparam logic [7:0] CODE_SPACE     = 8'd32;

  localparam logic [15:0] RESET_CELL = 16'h0720;
  localparam logic [7:0]  ATTR_RESET = 8'h07;

  localparam int   PADDR_W  = 3;
  localparam logic REG_ATTR = 1'b0;

endpackage
`default_nettype wire

/* src/text_console_writer_top.sv */
// Text console writer: screen memory, cursor, sequencer and register port.
//
// Input channel (valid/ready) carries tcw_in_t beats: a put writes char_code at
// the cursor with the current attribute (newline and backspace move the cursor),
// a read returns the cell at cell_index. Every beat gives one tcw_out_t beat on
// the output channel with the cursor position after the step.
// An ordinary put or read executes the cycle after acceptance (ST_EXEC); its
// result is registered in the output register as the block returns to ST_IDLE,
// where the next beat can be taken. A put that runs past the last row scrolls:
// the screen is copied up one row through the memory, one cell a cycle, then the
// bottom row is blanked; its result is registered from ST_DONE once the scroll
// ends, and the next beat follows from ST_IDLE. One item is in work at a time.
// After reset the memory is swept to blank grey-on-black cells, and no beat is
// accepted until the sweep ends; the register port is live throughout. A stalled
// receiver holds the result in the output register; the next beat is still
// accepted and finishes when that register frees.
// text_attribute sits at byte address 0 of the APB port; pready is always high.
`default_nettype none
`include "text_console_writer_top_assert.svh"
module text_console_writer_top import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tcw_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tcw_out_t           out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_DONE
  } state_e;

  state_e        state_q, state_d;
  logic [7:0]    attr_q, attr_d;
  logic          item_act_q, item_act_d;
  logic [7:0]    item_char_q, item_char_d;
  logic          rd_ok_q, rd_ok_d;
  logic          scrolled_q, scrolled_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] sc_rd_q, sc_rd_d;
  logic [AW-1:0] sc_wr_q, sc_wr_d;
  logic          sc_rd_done_q, sc_rd_done_d;
  logic          sc_pend_q, sc_pend_d;
  logic          out_valid_q, out_valid_d;
  tcw_out_t      out_q, out_d;

  logic          accept;
  logic          slot_free;
  logic          out_load;
  logic          cfg_wr;
  logic          sc_copy;
  logic [15:0]   blank;
  logic [15:0]   res_value;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  logic          commit;
  tcw_plan_t     plan;
  logic [AW-1:0] cur_waddr;
  logic [7:0]    cur_char;
  logic [10:0]   cur_pos;
  logic [10:0]   nxt_pos;

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_code_i (item_char_q),
    .commit_i    (commit),
    .plan_o      (plan),
    .wr_addr_o   (cur_waddr),
    .wr_char_o   (cur_char),
    .pos_o       (cur_pos),
    .nxt_pos_o   (nxt_pos)
  );

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ATTR);
  assign prdata = (paddr[2] == REG_ATTR) ? {24'b0, attr_q} : '0;
  assign attr_d = cfg_wr ? pwdata[7:0] : attr_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign blank      = {attr_q, CODE_SPACE};
  assign res_value  = (item_act_q == ACT_READ && rd_ok_q) ? ram_rdata : '0;
  assign sc_copy    = sc_wr_q < AW'(CELLS - COLUMNS);

  always_comb begin
    state_d      = state_q;
    item_act_d   = item_act_q;
    item_char_d  = item_char_q;
    rd_ok_d      = rd_ok_q;
    scrolled_d   = scrolled_q;
    clr_d        = clr_q;
    sc_rd_d      = sc_rd_q;
    sc_wr_d      = sc_wr_q;
    sc_rd_done_d = sc_rd_done_q;
    sc_pend_d    = 1'b0;
    out_load     = 1'b0;
    out_d        = out_q;
    commit       = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = cur_waddr;
    ram_wdata    = {attr_q, cur_char};
    ram_re       = 1'b0;
    ram_raddr    = AW'(in_data_i.cell_index);

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = RESET_CELL;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          item_act_d  = in_data_i.action;
          item_char_d = in_data_i.char_code;
          rd_ok_d     = 32'(in_data_i.cell_index) < CELLS;
          scrolled_d  = 1'b0;
          ram_re      = (in_data_i.action == ACT_READ);
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (item_act_q == ACT_PUT) begin
          commit = 1'b1;
          ram_we = plan.cell_wr;
          if (plan.scroll) begin
            scrolled_d   = 1'b1;
            sc_rd_d      = AW'(COLUMNS);
            sc_wr_d      = '0;
            sc_rd_done_d = 1'b0;
            state_d      = ST_SCROLL;
          end else if (slot_free) begin
            out_load         = 1'b1;
            out_d.cursor_pos = nxt_pos;
            out_d.cell_value = '0;
            out_d.scrolled   = 1'b0;
            state_d          = ST_IDLE;
          end else begin
            state_d = ST_DONE;
          end
        end else if (slot_free) begin
          out_load         = 1'b1;
          out_d.cursor_pos = cur_pos;
          out_d.cell_value = res_value;
          out_d.scrolled   = 1'b0;
          state_d          = ST_IDLE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SCROLL: begin
        // read runs one row ahead; read data lands in the next cycle
        ram_re    = !sc_rd_done_q;
        ram_raddr = sc_rd_q;
        if (!sc_rd_done_q) begin
          sc_rd_d   = sc_rd_q + 1'b1;
          sc_pend_d = 1'b1;
          if (sc_rd_q == AW'(CELLS - 1)) begin
            sc_rd_done_d = 1'b1;
          end
        end
        ram_we    = sc_copy ? sc_pend_q : 1'b1;
        ram_waddr = sc_wr_q;
        ram_wdata = sc_copy ? ram_rdata : blank;
        if (ram_we) begin
          sc_wr_d = sc_wr_q + 1'b1;
          if (sc_wr_q == AW'(CELLS - 1)) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_load         = 1'b1;
          out_d.cursor_pos = cur_pos;
          out_d.cell_value = res_value;
          out_d.scrolled   = scrolled_q;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      attr_q       <= ATTR_RESET;
      clr_q        <= '0;
      sc_rd_done_q <= 1'b0;
      sc_pend_q    <= 1'b0;
      scrolled_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      item_act_q   <= ACT_PUT;
      item_char_q  <= '0;
      rd_ok_q      <= 1'b0;
      sc_rd_q      <= '0;
      sc_wr_q      <= '0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      attr_q       <= attr_d;
      clr_q        <= clr_d;
      sc_rd_done_q <= sc_rd_done_d;
      sc_pend_q    <= sc_pend_d;
      scrolled_q   <= scrolled_d;
      out_valid_q  <= out_valid_d;
      item_act_q   <= item_act_d;
      item_char_q  <= item_char_d;
      rd_ok_q      <= rd_ok_d;
      sc_rd_q      <= sc_rd_d;
      sc_wr_q      <= sc_wr_d;
      out_q        <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `TCW_ASSERT_NXT(a_accept_exec, in_valid_i && in_ready_o, state_q == ST_EXEC, "accepted beat did not start execution")
  `TCW_ASSERT_IMP(a_load_free, out_load, !out_valid_q || out_ready_i, "result overwrote a waiting beat")
  `TCW_ASSERT_IMP(a_scroll_lag, state_q == ST_SCROLL && sc_copy && sc_pend_q, (32'(ram_waddr) + COLUMNS) == 32'($past(ram_raddr)), "scroll copy not one row behind its read")

endmodule
`default_nettype wire

/* src/tcw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* src/tcw_cursor.sv */
// Cursor registers and the put decode: which cell to write, where the cursor goes.
`default_nettype none
`include "text_console_writer_top_assert.svh"
module tcw_cursor import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int CW = $clog2(COLUMNS),
  localparam int RW = $clog2(ROWS),
  localparam int AW = $clog2(COLUMNS * ROWS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    char_code_i,
  input  logic          commit_i,
  output tcw_plan_t     plan_o,
  output logic [AW-1:0] wr_addr_o,
  output logic [7:0]    wr_char_o,
  output logic [10:0]   pos_o,
  output logic [10:0]   nxt_pos_o
);

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW:0]   col_t;
  logic [RW:0]   row_t;
  logic [AW-1:0] lin_cur;
  logic [AW-1:0] lin_nxt;

  assign lin_cur = AW'(AW'(row_q) * AW'(COLUMNS)) + AW'(col_q);
  assign lin_nxt = AW'(AW'(row_t[RW-1:0]) * AW'(COLUMNS)) + AW'(col_t[CW-1:0]);

  always_comb begin
    col_t     = {1'b0, col_q};
    row_t     = {1'b0, row_q};
    plan_o    = '0;
    wr_addr_o = lin_cur;
    wr_char_o = char_code_i;
    case (char_code_i)
      CODE_NEWLINE: begin
        col_t = '0;
        row_t = row_t + 1'b1;
      end
      CODE_BACKSPACE: begin
        // nothing to do at home; otherwise the cell just behind the cursor
        if (col_q != '0 || row_q != '0) begin
          plan_o.cell_wr = 1'b1;
          wr_addr_o      = lin_cur - AW'(1);
          wr_char_o      = CODE_SPACE;
          if (col_q == '0) begin
            row_t = row_t - 1'b1;
            col_t = (CW+1)'(COLUMNS - 1);
          end else begin
            col_t = col_t - 1'b1;
          end
        end
      end
      default: begin
        plan_o.cell_wr = 1'b1;
        col_t          = col_t + 1'b1;
      end
    endcase
    if (col_t >= (CW+1)'(COLUMNS)) begin
      col_t = '0;
      row_t = row_t + 1'b1;
    end
    if (row_t >= (RW+1)'(ROWS)) begin
      plan_o.scroll = 1'b1;
      row_t         = (RW+1)'(ROWS - 1);
    end
    col_d = commit_i ? col_t[CW-1:0] : col_q;
    row_d = commit_i ? row_t[RW-1:0] : row_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign pos_o     = 11'(lin_cur);
  assign nxt_pos_o = 11'(lin_nxt);

  `TCW_ASSERT_NXT(a_scroll_last_row, commit_i && plan_o.scroll, row_q == RW'(ROWS - 1), "scroll left cursor off the last row")
  `TCW_ASSERT_IMP(a_col_range, 1'b1, 32'(col_q) < COLUMNS, "cursor column out of range")
  `TCW_ASSERT_IMP(a_row_range, 1'b1, 32'(row_q) < ROWS, "cursor row out of range")

endmodule
`default_nettype wire
